@@ hw/rtl/bmptc_pkg.sv @@
// Shared types, constants and helper functions of the barometric compensation core.
`timescale 1ns / 1ps
package bmptc_pkg;

	localparam int DW         = 32;
	localparam int DIV_STAGES = DW;
	localparam int Q_DEPTH    = 4;
	localparam int Q_AW       = $clog2(Q_DEPTH);
	localparam int UP_W       = 19;
	localparam int ADDR_W     = 5;

	localparam logic [31:0] C_T_OFS = 32'd4000;
	localparam logic [31:0] C_HALF  = 32'd32768;
	localparam logic [15:0] C_SCALE = 16'd50000;
	localparam logic [31:0] C_K1    = 32'd3038;
	localparam logic [31:0] C_K2    = 32'hFFFF_E343;
	localparam logic [31:0] C_K3    = 32'd3791;
	localparam logic [31:0] C_MSB   = 32'h8000_0000;

	typedef enum logic [2:0] {
		REG_AC1_AC2 = 3'd0,
		REG_AC3_AC4 = 3'd1,
		REG_AC5_AC6 = 3'd2,
		REG_B1_B2   = 3'd3,
		REG_MC_MD   = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [15:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
	} cal_t;

	typedef struct packed {
		logic [15:0]     ut;
		logic [UP_W-1:0] up;
		logic [1:0]      oss;
	} smp_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef struct packed {
		logic [31:0] temperature;
		logic [31:0] pressure;
		logic        divide_error;
	} res_t;

	typedef struct packed {
		logic [1:0]      oss;
		logic [UP_W-1:0] up;
		logic            terr, tneg, post, perr;
		logic [31:0]     x1t, tnum, tden, b5, temp, b6, msq, mac2, mac3, sq, x2b, x1c;
		logic [31:0]     mb2, mb1, x3, x2c, b3, x3b, b4p, b7, b4, dnum, p, ps, m7, m3;
		logic [31:0]     msq2, pres;
	} ctx_t;

	function automatic logic [31:0] sx16(input logic [15:0] v);
		sx16 = {{16{v[15]}}, v};
	endfunction

	function automatic logic [31:0] sra(input logic [31:0] v, input int n);
		sra = 32'($signed(v) >>> n);
	endfunction

endpackage

@@ hw/rtl/bmptc_if.sv @@
// Valid/ready channel interfaces for samples and compensated results.
`timescale 1ns / 1ps
interface bmptc_smp_if;
	logic        valid;
	logic        ready;
	logic [15:0] raw_temperature;
	logic [23:0] raw_pressure_bytes;
	logic [1:0]  oversampling;
	modport source (output valid, raw_temperature, raw_pressure_bytes, oversampling,
		input ready);
	modport sink (input valid, raw_temperature, raw_pressure_bytes, oversampling,
		output ready);
endinterface

interface bmptc_res_if;
	logic        valid;
	logic        ready;
	logic [31:0] temperature;
	logic [31:0] pressure;
	logic        divide_error;
	modport source (output valid, temperature, pressure, divide_error, input ready);
	modport sink (input valid, temperature, pressure, divide_error, output ready);
endinterface

@@ hw/rtl/bmptc_div.sv @@
// Pipelined restoring unsigned divider, one quotient bit per stage.
`timescale 1ns / 1ps
module bmptc_div import bmptc_pkg::*; (
	input  logic          clk,
	input  logic          en,
	input  logic [DW-1:0] num,
	input  logic [DW-1:0] den,
	output logic [DW-1:0] quo
);
	logic [DW-1:0] num_q [DIV_STAGES];
	logic [DW-1:0] rem_q [DIV_STAGES];
	logic [DW-1:0] den_q [DIV_STAGES];

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stg
		logic [DW-1:0] n_in, r_in, d_in;
		logic [DW:0]   trial;
		logic          ge;
		if (k == 0) begin : g_first
			assign n_in = num;
			assign r_in = '0;
			assign d_in = den;
		end else begin : g_next
			assign n_in = num_q[k-1];
			assign r_in = rem_q[k-1];
			assign d_in = den_q[k-1];
		end
		assign trial = {r_in, n_in[DW-1]};
		assign ge    = trial >= {1'b0, d_in};
		always_ff @(posedge clk) begin
			if (en) begin
				num_q[k] <= {n_in[DW-2:0], ge};
				rem_q[k] <= ge ? DW'(trial - {1'b0, d_in}) : trial[DW-1:0];
				den_q[k] <= d_in;
			end
		end
	end

	assign quo = num_q[DIV_STAGES-1];
endmodule

@@ hw/rtl/bmptc_front.sv @@
// Front end: accepts samples, aligns the raw pressure word and hands items to the queue.
`timescale 1ns / 1ps
module bmptc_front import bmptc_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	bmptc_smp_if.sink     sample,
	input  q_stat_t       q_stat,
	output logic          push,
	output smp_t          push_data
);
	logic        v_q;
	smp_t        d_q;
	logic [23:0] up_full;

	assign up_full      = sample.raw_pressure_bytes >> (4'd8 - {2'b00, sample.oversampling});
	assign push         = v_q && !q_stat.full;
	assign push_data    = d_q;
	assign sample.ready = !v_q || !q_stat.full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (sample.ready) begin
			v_q <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.ready && sample.valid) begin
			d_q.ut  <= sample.raw_temperature;
			d_q.up  <= up_full[UP_W-1:0];
			d_q.oss <= sample.oversampling;
		end
	end
endmodule

@@ hw/rtl/bmptc_queue.sv @@
// Short FIFO that decouples the front end from the compensation pipeline.
`timescale 1ns / 1ps
module bmptc_queue import bmptc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  smp_t    push_data,
	input  logic    pop,
	output smp_t    head,
	output q_stat_t stat
);
	smp_t            mem_q [Q_DEPTH];
	logic [Q_AW-1:0] wp_q, rp_q;
	logic [Q_AW:0]   cnt_q;

	assign stat.full  = cnt_q == (Q_AW+1)'(Q_DEPTH);
	assign stat.empty = cnt_q == '0;
	assign head       = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop) rp_q <= rp_q + 1'b1;
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= push_data;
	end
endmodule

@@ hw/rtl/bmptc_back.sv @@
// Back end: the compensation pipeline with its two dividers and the output register.
`timescale 1ns / 1ps
module bmptc_back import bmptc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  cal_t    cal,
	input  smp_t    head,
	input  q_stat_t q_stat,
	output logic    pop,
	output logic    res_valid,
	input  logic    res_ready,
	output res_t    res
);
	localparam int NSTG = 16 + 2 * DIV_STAGES;

	logic            en;
	logic [NSTG-1:0] vld_q;
	logic            out_v_q;
	res_t            out_q;
	ctx_t c1_s1, c2_s2, c3_s3, c4_s4, c5_s5, c6_s6, c7_s7, c8_s8, c9_s9, c10_s10, c11_s11;
	ctx_t c12_s12, c13_s13, c14_s14, c15_s15, c16_s16;
	ctx_t n1, n2, n3, n4, n5, n6, n7, n8, n9, n10, n11, n12, n13, n14, n15, n16;
	ctx_t dl1_q [DIV_STAGES];
	ctx_t dl2_q [DIV_STAGES];
	logic [31:0] tq, pq;
	logic [31:0] v9;

	assign en        = !out_v_q || res_ready;
	assign pop       = en && !q_stat.empty;
	assign res_valid = out_v_q;
	assign res       = out_q;

	// Temperature front: x1 and the signed divisor.
	always_comb begin
		n1     = c1_s1;
		n1.oss = head.oss;
		n1.up  = head.up;
		n1.x1t = ({16'd0, head.ut} - {16'd0, cal.ac6}) * {16'd0, cal.ac5};
	end
	always_comb begin
		n2      = c1_s1;
		n2.x1t  = sra(c1_s1.x1t, 15);
		n2.tnum = sx16(cal.mc) << 11;
		n2.tden = sra(c1_s1.x1t, 15) + sx16(cal.md);
	end
	always_comb begin
		n3      = c2_s2;
		n3.terr = c2_s2.tden == '0;
		n3.tneg = c2_s2.tnum[31] ^ c2_s2.tden[31];
		n3.tnum = c2_s2.tnum[31] ? -c2_s2.tnum : c2_s2.tnum;
		n3.tden = c2_s2.tden[31] ? -c2_s2.tden : c2_s2.tden;
	end

	bmptc_div u_tdiv (.clk(clk), .en(en), .num(c3_s3.tnum), .den(c3_s3.tden), .quo(tq));

	// Temperature result and the pressure coefficient chain.
	always_comb begin
		n4    = dl1_q[DIV_STAGES-1];
		n4.b5 = dl1_q[DIV_STAGES-1].x1t + (dl1_q[DIV_STAGES-1].tneg ? -tq : tq);
	end
	always_comb begin
		n5      = c4_s4;
		n5.temp = sra(c4_s4.b5 + 32'd8, 4);
		n5.b6   = c4_s4.b5 - C_T_OFS;
		n5.msq  = (c4_s4.b5 - C_T_OFS) * (c4_s4.b5 - C_T_OFS);
		n5.mac2 = sx16(cal.ac2) * (c4_s4.b5 - C_T_OFS);
		n5.mac3 = sx16(cal.ac3) * (c4_s4.b5 - C_T_OFS);
	end
	always_comb begin
		n6     = c5_s5;
		n6.sq  = sra(c5_s5.msq, 12);
		n6.x2b = sra(c5_s5.mac2, 11);
		n6.x1c = sra(c5_s5.mac3, 13);
	end
	always_comb begin
		n7     = c6_s6;
		n7.mb2 = sx16(cal.b2) * c6_s6.sq;
		n7.mb1 = sx16(cal.b1) * c6_s6.sq;
	end
	always_comb begin
		n8     = c7_s7;
		n8.x3  = sra(c7_s7.mb2, 11) + c7_s7.x2b;
		n8.x2c = sra(c7_s7.mb1, 16);
	end
	// B3 is a truncating divide by four: bias negative values before the shift.
	always_comb begin
		v9     = (((sx16(cal.ac1) << 2) + c8_s8.x3) << c8_s8.oss) + 32'd2;
		n9     = c8_s8;
		n9.b3  = sra(v9 + (v9[31] ? 32'd3 : 32'd0), 2);
		n9.x3b = sra(c8_s8.x1c + c8_s8.x2c + 32'd2, 2);
	end
	always_comb begin
		n10     = c9_s9;
		n10.b4p = {16'd0, cal.ac4} * (c9_s9.x3b + C_HALF);
		n10.b7  = ({{(32-UP_W){1'b0}}, c9_s9.up} - c9_s9.b3)
			* {16'd0, C_SCALE >> c9_s9.oss};
	end
	// A large B7 is divided first and doubled after, so the dividend stays in range.
	always_comb begin
		n11      = c10_s10;
		n11.b4   = c10_s10.b4p >> 15;
		n11.perr = (c10_s10.b4p >> 15) == '0;
		n11.post = c10_s10.b7 >= C_MSB;
		n11.dnum = (c10_s10.b7 >= C_MSB) ? c10_s10.b7 : (c10_s10.b7 << 1);
	end

	bmptc_div u_pdiv (.clk(clk), .en(en), .num(c11_s11.dnum), .den(c11_s11.b4), .quo(pq));

	always_comb begin
		n12   = dl2_q[DIV_STAGES-1];
		n12.p = dl2_q[DIV_STAGES-1].post ? (pq << 1) : pq;
	end
	always_comb begin
		n13    = c12_s12;
		n13.ps = sra(c12_s12.p, 8);
		n13.m7 = c12_s12.p * C_K2;
	end
	always_comb begin
		n14      = c13_s13;
		n14.msq2 = c13_s13.ps * c13_s13.ps;
	end
	always_comb begin
		n15    = c14_s14;
		n15.m3 = c14_s14.msq2 * C_K1;
	end
	always_comb begin
		n16      = c15_s15;
		n16.pres = c15_s15.p + sra(sra(c15_s15.m3, 16) + sra(c15_s15.m7, 16) + C_K3, 4);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c1_s1   <= n1;
			c2_s2   <= n2;
			c3_s3   <= n3;
			dl1_q[0] <= c3_s3;
			for (int i = 1; i < DIV_STAGES; i++) dl1_q[i] <= dl1_q[i-1];
			c4_s4   <= n4;
			c5_s5   <= n5;
			c6_s6   <= n6;
			c7_s7   <= n7;
			c8_s8   <= n8;
			c9_s9   <= n9;
			c10_s10 <= n10;
			c11_s11 <= n11;
			dl2_q[0] <= c11_s11;
			for (int i = 1; i < DIV_STAGES; i++) dl2_q[i] <= dl2_q[i-1];
			c12_s12 <= n12;
			c13_s13 <= n13;
			c14_s14 <= n14;
			c15_s15 <= n15;
			c16_s16 <= n16;
			out_q.temperature  <= c16_s16.terr ? '0 : c16_s16.temp;
			out_q.pressure     <= (c16_s16.terr || c16_s16.perr) ? '0 : c16_s16.pres;
			out_q.divide_error <= c16_s16.terr || c16_s16.perr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			out_v_q <= 1'b0;
		end else if (en) begin
			vld_q   <= {vld_q[NSTG-2:0], !q_stat.empty};
			out_v_q <= vld_q[NSTG-1];
		end
	end
endmodule

@@ hw/rtl/baro_temp_pressure_compensation_core.sv @@
// Top level: calibration registers, front end, queue and compensation pipeline.
// Throughput: one item per cycle while the result output is not stalled; every stage,
// each divider step included, is a register stage.
// Result stalls freeze the pipeline; the queue and front register then hold up to five items.
// Reset (arst_n low, asynchronous) empties the pipeline and clears all calibration words.
`timescale 1ns / 1ps
module baro_temp_pressure_compensation_core import bmptc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	bmptc_smp_if.sink         sample,
	bmptc_res_if.source       result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);
	logic [31:0] ac12_q, ac34_q, ac56_q, b12_q, mcmd_q;
	logic        wr;
	reg_idx_t    idx;
	cal_t        cal;
	q_stat_t     q_stat;
	logic        push, pop;
	smp_t        push_data, head;
	res_t        res;

	// Calibration registers sit on 4-byte boundaries; writes beyond the last are dropped.
	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[4:2]);
	assign wr     = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ac12_q <= '0;
			ac34_q <= '0;
			ac56_q <= '0;
			b12_q  <= '0;
			mcmd_q <= '0;
		end else if (wr) begin
			unique case (idx)
				REG_AC1_AC2: ac12_q <= pwdata;
				REG_AC3_AC4: ac34_q <= pwdata;
				REG_AC5_AC6: ac56_q <= pwdata;
				REG_B1_B2:   b12_q  <= pwdata;
				REG_MC_MD:   mcmd_q <= pwdata;
				default:     ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_AC1_AC2: prdata = ac12_q;
			REG_AC3_AC4: prdata = ac34_q;
			REG_AC5_AC6: prdata = ac56_q;
			REG_B1_B2:   prdata = b12_q;
			REG_MC_MD:   prdata = mcmd_q;
			default:     prdata = '0;
		endcase
	end

	// Unpack the coefficient pairs; upper half is the first coefficient of each word.
	assign cal.ac1 = ac12_q[31:16];
	assign cal.ac2 = ac12_q[15:0];
	assign cal.ac3 = ac34_q[31:16];
	assign cal.ac4 = ac34_q[15:0];
	assign cal.ac5 = ac56_q[31:16];
	assign cal.ac6 = ac56_q[15:0];
	assign cal.b1  = b12_q[31:16];
	assign cal.b2  = b12_q[15:0];
	assign cal.mc  = mcmd_q[31:16];
	assign cal.md  = mcmd_q[15:0];

	bmptc_front u_front (
		.clk(clk), .arst_n(arst_n), .sample(sample), .q_stat(q_stat),
		.push(push), .push_data(push_data)
	);

	bmptc_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .push_data(push_data),
		.pop(pop), .head(head), .stat(q_stat)
	);

	bmptc_back u_back (
		.clk(clk), .arst_n(arst_n), .cal(cal), .head(head), .q_stat(q_stat), .pop(pop),
		.res_valid(result.valid), .res_ready(result.ready), .res(res)
	);

	assign result.temperature  = res.temperature;
	assign result.pressure     = res.pressure;
	assign result.divide_error = res.divide_error;

	// Any divide error forces the pressure field to zero.
	a_err_pres: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.divide_error |-> result.pressure == '0)
		else $error("pressure not cleared on divide error");

	// A completed write to the first register lands in it on the next cycle.
	a_cfg_wr: assert property (@(posedge clk) disable iff (!arst_n)
		wr && idx == REG_AC1_AC2 |=> ac12_q == $past(pwdata))
		else $error("calibration write lost");

	// The queue never takes an item while it is full.
	a_q_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.full |-> !push)
		else $error("queue overflow");
endmodule
